[rtl/core/scrolling_comment_track_allocator_macros.svh]
// Assertion macros for the scrolling comment track allocator.
// Used by the port checker; no other dependencies.
`ifndef SCROLLING_COMMENT_TRACK_ALLOCATOR_MACROS_SVH
`define SCROLLING_COMMENT_TRACK_ALLOCATOR_MACROS_SVH

// same-cycle implication, quiet during reset
`define SCTA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scta check failed");

// next-cycle implication, quiet during reset
`define SCTA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scta check failed");

`endif

[rtl/core/sctalloc_pkg.sv]
// Shared types and constants for the scrolling comment track allocator.
// No dependencies.
package sctalloc_pkg;
  localparam int SLOTS   = 256;
  localparam int TRACKS  = 64;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int TRK_W   = $clog2(TRACKS);
  localparam int EDGE_W  = 15;

  localparam logic [1:0] ST_PLACED = 2'd0;
  localparam logic [1:0] ST_POOL   = 2'd1;
  localparam logic [1:0] ST_TRACKS = 2'd2;
  localparam logic [1:0] ST_TICK   = 2'd3;

  localparam logic [2:0] CFG_SW  = 3'd0;
  localparam logic [2:0] CFG_FR  = 3'd1;
  localparam logic [2:0] CFG_RT  = 3'd2;
  localparam logic [2:0] CFG_MA  = 3'd3;
  localparam logic [2:0] CFG_OV  = 3'd4;

  typedef struct packed {
    logic               busy;
    logic signed [15:0] left;
    logic [13:0]        width;
    logic [TRK_W-1:0]   track;
  } slot_t;
endpackage

[rtl/core/scrolling_comment_track_allocator.sv]
// Scrolling comment track allocator, top level.
// Depends on sctalloc_pkg, sctalloc_slot_cell, sctalloc_track_cell, sctalloc_div.
//
// Input items: in_tuser is the request kind (0 add, 1 tick), in_tdata carries
// the text width of an add. Each item gives exactly one result item:
// out_tuser is the status, out_tdata holds slot, track and freed count.
// Slot state lives in a ring of 256 cells that rotates once per request, so
// each slot passes the head cell in ascending order; track edges sit in a
// ring of 64 cells that rotates once for the minimum search of an add and
// takes broadcast writes otherwise.
// An add runs the track search (S_TSCAN) and then the slot rotation
// (S_SSCAN); a tick runs the track clear (S_CLR) and then the slot
// rotation. Both end in S_DONE, whose exit registers the result and
// returns to S_IDLE, where the next item can be taken. One item is
// worked on at a time; the next is taken as soon as the result is registered,
// even while out_tready holds it back. That item then waits in its last cycle
// until the held result goes, and the input stays blocked meanwhile.
// Writing screen width or scroll frames restarts the step division;
// no item is accepted until the division is done. After reset all slots
// are free, tracks empty, registers at their defaults, and the step division
// runs first.
module scrolling_comment_track_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [13:0] text_width
  input  logic        in_tuser,   // [0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] slot_index, [13:8] track_index, [22:14] freed_count
  output logic [1:0]  out_tuser,  // [1:0] status
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  import sctalloc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_TSCAN = 5'b00010,
    S_CLR   = 5'b00100,
    S_SSCAN = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [12:0] sw_r;
  logic [9:0]  fr_r;
  logic [6:0]  rt_r;
  logic [8:0]  ma_r;
  logic        ov_r;
  logic [12:0] step_r;
  logic        go_r;
  logic        div_busy, div_done;
  logic [12:0] div_q;

  logic        tick_r;
  logic [13:0] w_r;
  logic [SLOT_W:0]   scnt_r;
  logic [TRK_W-1:0]  tcnt_r;
  logic              have_r;
  logic [EDGE_W-1:0] best_r;
  logic [TRK_W-1:0]  bidx_r;
  logic              trk_ok_r;
  logic              found_r;
  logic [SLOT_W-1:0] slot_r;
  logic [SLOT_W:0]   freed_r;

  logic        ov_valid_r;
  logic [23:0] ov_data_r;
  logic [1:0]  ov_user_r;

  // configuration and step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r <= 13'd1920;
      fr_r <= 10'd100;
      rt_r <= 7'd20;
      ma_r <= 9'd200;
      ov_r <= 1'b0;
      go_r <= 1'b1;
    end else begin
      go_r <= cfg_wr_en && (cfg_index == CFG_SW || cfg_index == CFG_FR);
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_SW:  sw_r <= cfg_data;
          CFG_FR:  fr_r <= cfg_data[9:0];
          CFG_RT:  rt_r <= cfg_data[6:0];
          CFG_MA:  ma_r <= cfg_data[8:0];
          CFG_OV:  ov_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
    if (div_done) begin
      step_r <= div_q;
    end
  end

  sctalloc_div u_div (
    .clk(clk), .rst_n(rst_n), .start(go_r), .dividend(sw_r), .divisor(fr_r),
    .busy(div_busy), .done(div_done), .quot(div_q)
  );

  logic [SLOT_W:0] n_act;
  logic [6:0]      n_trk;
  assign n_act = (ma_r > 9'(SLOTS)) ? (SLOT_W+1)'(SLOTS) : ma_r;
  assign n_trk = (rt_r > 7'(TRACKS)) ? 7'(TRACKS) : rt_r;

  logic in_acc;
  assign in_tready = state_r == S_IDLE && !go_r && !div_busy;
  assign in_acc    = in_tvalid && in_tready;

  // slot ring
  slot_t sq [SLOTS];
  slot_t head, head_nxt;
  logic  s_shift;
  assign s_shift = state_r == S_SSCAN;
  assign head    = sq[0];

  for (genvar k = 0; k < SLOTS; k++) begin : g_slot
    slot_t din;
    if (k == SLOTS - 1) begin : g_wrap
      assign din = head_nxt;
    end else begin : g_link
      assign din = sq[k+1];
    end
    sctalloc_slot_cell u_cell (
      .clk(clk), .rst_n(rst_n), .shift(s_shift), .d_in(din), .q(sq[k])
    );
  end

  logic               in_rng;
  logic signed [16:0] moved, neg_w, edge_new;
  logic               gone, tick_hit, add_hit;
  logic [EDGE_W-1:0]  place_edge;

  assign in_rng     = scnt_r < n_act;
  assign moved      = 17'($signed({head.left[15], head.left}) - $signed({4'b0, step_r}));
  assign neg_w      = -$signed({3'b0, head.width});
  assign gone       = moved < neg_w;
  assign edge_new   = 17'(moved + $signed({3'b0, head.width}));
  assign tick_hit   = s_shift && tick_r && in_rng && head.busy;
  assign add_hit    = s_shift && !tick_r && in_rng && !head.busy && !found_r;
  assign place_edge = EDGE_W'({2'b0, sw_r} + {1'b0, w_r});

  always_comb begin
    head_nxt = head;
    if (tick_hit) begin
      head_nxt.left = moved[15:0];
      head_nxt.busy = !gone;
    end else if (add_hit && trk_ok_r) begin
      head_nxt.busy  = 1'b1;
      head_nxt.left  = $signed({3'b0, sw_r});
      head_nxt.width = w_r;
      head_nxt.track = bidx_r;
    end
  end

  // track ring
  logic [EDGE_W-1:0] tq [TRACKS];
  logic              t_shift, t_clr, t_wr_en, t_mx_en;
  logic [TRK_W-1:0]  t_sel;
  logic [EDGE_W-1:0] t_val;

  assign t_shift = state_r == S_TSCAN;
  assign t_clr   = state_r == S_CLR;
  assign t_wr_en = add_hit && trk_ok_r;
  assign t_mx_en = tick_hit && !gone && edge_new > 17'sd0;
  assign t_sel   = t_wr_en ? bidx_r : head.track;
  assign t_val   = t_wr_en ? place_edge : edge_new[EDGE_W-1:0];

  for (genvar k = 0; k < TRACKS; k++) begin : g_trk
    logic [EDGE_W-1:0] din;
    logic              hit;
    assign din = tq[(k + 1) % TRACKS];
    assign hit = t_sel == TRK_W'(k);
    sctalloc_track_cell u_cell (
      .clk(clk), .rst_n(rst_n), .clr(t_clr), .shift(t_shift), .d_in(din),
      .wr(t_wr_en && hit), .mx(t_mx_en && hit), .val(t_val), .q(tq[k])
    );
  end

  // control
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_acc) state_nxt = in_tuser ? S_CLR : S_TSCAN;
      S_TSCAN: if (tcnt_r == TRK_W'(TRACKS - 1)) state_nxt = S_SSCAN;
      S_CLR:   state_nxt = S_SSCAN;
      S_SSCAN: if (scnt_r == (SLOT_W+1)'(SLOTS - 1)) state_nxt = S_DONE;
      S_DONE:  if (!ov_valid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  logic t_take;
  assign t_take = {1'b0, tcnt_r} < n_trk && (!have_r || tq[0] < best_r);

  // tracks are full when the smallest edge, after the last candidate, passes the screen and overlap is off
  function automatic logic have_r_nxt_full();
    logic              hv;
    logic [EDGE_W-1:0] bs;
    hv = have_r || t_take;
    bs = t_take ? tq[0] : best_r;
    return hv && bs > {2'b0, sw_r} && !ov_r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      ov_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && state_nxt == S_IDLE) begin
        ov_valid_r <= 1'b1;
      end else if (out_tready) begin
        ov_valid_r <= 1'b0;
      end
    end

    if (in_acc) begin
      tick_r  <= in_tuser;
      w_r     <= in_tdata[13:0];
      tcnt_r  <= '0;
      scnt_r  <= '0;
      have_r  <= 1'b0;
      best_r  <= '0;
      bidx_r  <= '0;
      found_r <= 1'b0;
      slot_r  <= '0;
      freed_r <= '0;
    end
    if (t_shift) begin
      tcnt_r <= tcnt_r + TRK_W'(1);
      if (t_take) begin
        have_r <= 1'b1;
        best_r <= tq[0];
        bidx_r <= tcnt_r;
      end
    end
    if (state_r == S_TSCAN && state_nxt == S_SSCAN) begin
      trk_ok_r <= !(have_r_nxt_full());
    end
    if (t_clr) begin
      trk_ok_r <= 1'b1;
    end
    if (s_shift) begin
      scnt_r <= scnt_r + (SLOT_W+1)'(1);
      if (add_hit) begin
        found_r <= 1'b1;
        slot_r  <= scnt_r[SLOT_W-1:0];
      end
      if (tick_hit && gone) begin
        freed_r <= freed_r + (SLOT_W+1)'(1);
      end
    end
    if (state_r == S_DONE && state_nxt == S_IDLE) begin
      if (tick_r) begin
        ov_user_r <= ST_TICK;
        ov_data_r <= {1'b0, freed_r, 14'd0};
      end else if (!found_r) begin
        ov_user_r <= ST_POOL;
        ov_data_r <= '0;
      end else if (!trk_ok_r) begin
        ov_user_r <= ST_TRACKS;
        ov_data_r <= '0;
      end else begin
        ov_user_r <= ST_PLACED;
        ov_data_r <= {10'd0, bidx_r, slot_r};
      end
    end
  end

  assign out_tvalid = ov_valid_r;
  assign out_tdata  = ov_data_r;
  assign out_tuser  = ov_user_r;
endmodule

[rtl/core/sctalloc_slot_cell.sv]
// One slot of the rotating slot ring.
// Depends on sctalloc_pkg.
module sctalloc_slot_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                shift,
  input  sctalloc_pkg::slot_t d_in,
  output sctalloc_pkg::slot_t q
);
  import sctalloc_pkg::*;

  slot_t q_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      q_r <= d_in;
    end
    if (!rst_n) begin
      q_r.busy <= 1'b0;
    end
  end

  assign q = q_r;
endmodule

[rtl/core/sctalloc_track_cell.sv]
// One track edge: rotates for the minimum search, else takes broadcast writes.
// Depends on sctalloc_pkg.
module sctalloc_track_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            clr,
  input  logic                            shift,
  input  logic [sctalloc_pkg::EDGE_W-1:0] d_in,
  input  logic                            wr,
  input  logic                            mx,
  input  logic [sctalloc_pkg::EDGE_W-1:0] val,
  output logic [sctalloc_pkg::EDGE_W-1:0] q
);
  import sctalloc_pkg::*;

  logic [EDGE_W-1:0] edge_r;

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      edge_r <= '0;
    end else if (shift) begin
      edge_r <= d_in;
    end else if (wr || (mx && val > edge_r)) begin
      edge_r <= val;
    end
  end

  assign q = edge_r;
endmodule

[rtl/core/sctalloc_div.sv]
// Restoring divider for the scroll step, one quotient bit a cycle.
// Depends on sctalloc_pkg.
module sctalloc_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [12:0] dividend,
  input  logic [9:0]  divisor,
  output logic        busy,
  output logic        done,
  output logic [12:0] quot
);
  import sctalloc_pkg::*;

  logic [12:0] dvd_r;
  logic [9:0]  rem_r;
  logic [9:0]  dsr_r;
  logic [3:0]  cnt_r;
  logic        busy_r;
  logic [10:0] trial;
  logic        fit;

  assign trial = {rem_r, dvd_r[12]};
  assign fit   = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 4'd12;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 4'd1;
      if (cnt_r == 4'd0) begin
        busy_r <= 1'b0;
      end
    end
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dsr_r <= (divisor == 10'd0) ? 10'd1 : divisor;
    end else if (busy_r) begin
      rem_r <= fit ? 10'(trial - {1'b0, dsr_r}) : trial[9:0];
      dvd_r <= {dvd_r[11:0], fit};
    end
  end

  assign busy = busy_r;
  assign done = busy_r && cnt_r == 4'd0;
  assign quot = {dvd_r[11:0], fit};
endmodule

[rtl/core/sctalloc_chk.sv]
// Port-level checker for the scrolling comment track allocator, with its bind.
// Depends on sctalloc_pkg and scrolling_comment_track_allocator_macros.svh.
`include "scrolling_comment_track_allocator_macros.svh"

module sctalloc_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [1:0]  out_tuser
);
  import sctalloc_pkg::*;

  logic out_not_tick, out_fail;
  assign out_not_tick = out_tvalid && out_tuser != ST_TICK;
  assign out_fail     = out_tvalid && (out_tuser == ST_POOL || out_tuser == ST_TRACKS);

  // one item at a time: busy straight after an accept
  `SCTA_ASSERT_NEXT(a_busy_after_acc, in_tvalid && in_tready, !in_tready)
  `SCTA_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  `SCTA_ASSERT_NOW(a_freed_only_tick, out_not_tick, out_tdata[22:14] == 9'd0)
  `SCTA_ASSERT_NOW(a_fail_zero, out_fail, out_tdata[13:0] == 14'd0)
endmodule

bind scrolling_comment_track_allocator sctalloc_chk u_sctalloc_chk (.*);
